// ===== hdl/three_point_stencil_axpby_assert.svh =====
// Assertion macros for the three-point stencil block.
// Used by the port checker; expects clk and rst_n in the scope of use.
`ifndef THREE_POINT_STENCIL_AXPBY_ASSERT_SVH
`define THREE_POINT_STENCIL_AXPBY_ASSERT_SVH

// Same-cycle implication, off while in reset
`define TPSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset
`define TPSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tpsa_pkg.sv =====
// Shared constants and register map of the three-point stencil axpby block.
// No dependencies; used by the top level and its port checker.
package tpsa_pkg;

  // Default widths of the data lanes and of the row/column indexes
  localparam int DATA_BITS_DEF  = 32;
  localparam int INDEX_BITS_DEF = 16;

  // Width of the column length and column count registers
  localparam int LEN_BITS = 16;

  // Configuration port geometry
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 5;
  localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

  // Register word indexes (byte address = 4 * index)
  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_ROWS_PER_COL = 3'd0,
    REG_COL_TOTAL    = 3'd1,
    REG_ALPHA_RE     = 3'd2,
    REG_ALPHA_IM     = 3'd3,
    REG_BETA_RE      = 3'd4,
    REG_BETA_IM      = 3'd5
  } reg_idx_t;

endpackage

// ===== hdl/three_point_stencil_axpby.sv =====
// Three-point Laplacian stencil with complex axpby, streamed column-major.
// Depends on tpsa_pkg for the register map and default widths.
// Usage:
//   Input channel (in_valid / in_stall) carries one matrix element per
//   transfer: x and the old y, each complex Q(DATA_BITS/2) fixed point.
//   Result channel (out_valid / out_stall) carries new y values with their
//   row and column, a last flag for the final result of an input and an
//   end_of_matrix flag on the last row of the last column.
//   A row's result is produced when the next row arrives: row 0 gives no
//   result, middle rows give one, the last row of a column gives two (one if it is row 0).
//   Pipeline: a result passes through the token, multiplier and result registers;
//   the second result of a last row follows the first.
//   Throughput: one input per cycle while out_stall is low; an input that causes
//   two results holds the input side until its second result is issued, since the
//   token issue stage hands one result per cycle to the multiplier stage.
//   Stall: out_stall freezes the result register and backs up through the
//   multiplier and issue stages to in_stall; nothing is lost.
//   Reset (rst_n low, synchronous): pipeline emptied, counters and neighbor
//   history cleared, alpha = 1.0, beta = 0, one row per column, one column.
//   Configure through the APB-style port only while the block is idle.
module three_point_stencil_axpby #(
  parameter int DATA_BITS  = tpsa_pkg::DATA_BITS_DEF,
  parameter int INDEX_BITS = tpsa_pkg::INDEX_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [DATA_BITS-1:0]         in_x_re,
  input  logic signed [DATA_BITS-1:0]         in_x_im,
  input  logic signed [DATA_BITS-1:0]         in_y_old_re,
  input  logic signed [DATA_BITS-1:0]         in_y_old_im,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [DATA_BITS-1:0]         out_y_re,
  output logic signed [DATA_BITS-1:0]         out_y_im,
  output logic [INDEX_BITS-1:0]               out_row_index,
  output logic [INDEX_BITS-1:0]               out_col_index,
  output logic                                out_last,
  output logic                                out_end_of_matrix,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tpsa_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [tpsa_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [tpsa_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                pready
);
  import tpsa_pkg::*;

  localparam int FRAC_BITS = DATA_BITS / 2;
  localparam int PROD_W    = 2 * DATA_BITS;
  localparam int SUM_W     = PROD_W - FRAC_BITS + 2;
  localparam int CMP_W     = (INDEX_BITS > LEN_BITS) ? INDEX_BITS : LEN_BITS;

  localparam logic signed [DATA_BITS-1:0] D_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};
  localparam logic signed [DATA_BITS-1:0] D_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};
  localparam logic signed [DATA_BITS-1:0] D_ONE = DATA_BITS'(1) <<< FRAC_BITS;

  typedef struct packed {
    logic [INDEX_BITS-1:0] row;
    logic [INDEX_BITS-1:0] col;
    logic                  last;
    logic                  eom;
  } meta_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] lap_re;
    logic signed [DATA_BITS-1:0] lap_im;
    logic signed [DATA_BITS-1:0] y_re;
    logic signed [DATA_BITS-1:0] y_im;
    meta_t                       meta;
  } tok_t;

  // Clamp a wide signed value to the data lane
  function automatic logic signed [DATA_BITS-1:0] sat_d(input logic signed [SUM_W-1:0] v);
    logic signed [DATA_BITS-1:0] res;
    if (v > SUM_W'(D_MAX)) begin
      res = D_MAX;
    end else if (v < SUM_W'(D_MIN)) begin
      res = D_MIN;
    end else begin
      res = v[DATA_BITS-1:0];
    end
    return res;
  endfunction

  // Saturated a - 2*b + c
  function automatic logic signed [DATA_BITS-1:0] lap3(input logic signed [DATA_BITS-1:0] a,
                                                       input logic signed [DATA_BITS-1:0] b,
                                                       input logic signed [DATA_BITS-1:0] c);
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(a) - (SUM_W'(b) <<< 1) + SUM_W'(c);
    return sat_d(s);
  endfunction

  // Drop the fraction bits, rounding toward minus infinity
  function automatic logic signed [SUM_W-1:0] fshift(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] sh;
    sh = v >>> FRAC_BITS;
    return sh[SUM_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [LEN_BITS-1:0]         rows_per_col_r, col_total_r;
  logic signed [DATA_BITS-1:0] alpha_re_r, alpha_im_r, beta_re_r, beta_im_r;
  logic                        cfg_wr;
  reg_idx_t                    cfg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);
  assign pready  = 1'b1;

  // Return the addressed register
  always_comb begin
    unique case (cfg_idx)
      REG_ROWS_PER_COL: prdata = APB_DATA_BITS'(rows_per_col_r);
      REG_COL_TOTAL:    prdata = APB_DATA_BITS'(col_total_r);
      REG_ALPHA_RE:     prdata = APB_DATA_BITS'(alpha_re_r);
      REG_ALPHA_IM:     prdata = APB_DATA_BITS'(alpha_im_r);
      REG_BETA_RE:      prdata = APB_DATA_BITS'(beta_re_r);
      REG_BETA_IM:      prdata = APB_DATA_BITS'(beta_im_r);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Front end: position, neighbor history and result tokens
  // ---------------------------------------------------------------------
  logic [INDEX_BITS-1:0]       row_cnt_r, col_cnt_r;
  logic [INDEX_BITS-1:0]       row_cnt_nxt, col_cnt_nxt;
  logic signed [DATA_BITS-1:0] xp_re_r, xp_im_r, xp2_re_r, xp2_im_r;
  logic signed [DATA_BITS-1:0] yp_re_r, yp_im_r;
  logic [LEN_BITS-1:0]         nr_m1, nc_m1;
  logic                        last_row, last_col, row_ge1, row_ge2;
  logic signed [DATA_BITS-1:0] q_re, q_im, pb_re, pb_im;
  tok_t                        tok_a, tok_b;
  logic                        has_a, has_b;

  assign nr_m1    = (rows_per_col_r == '0) ? '0 : rows_per_col_r - 1'b1;
  assign nc_m1    = (col_total_r == '0) ? '0 : col_total_r - 1'b1;
  assign last_row = CMP_W'(row_cnt_r) >= CMP_W'(nr_m1);
  assign last_col = CMP_W'(col_cnt_r) >= CMP_W'(nc_m1);
  assign row_ge1  = row_cnt_r != '0;
  assign row_ge2  = row_cnt_r > INDEX_BITS'(1);

  // Neighbors outside the column read as zero
  assign q_re  = row_ge2 ? xp2_re_r : '0;
  assign q_im  = row_ge2 ? xp2_im_r : '0;
  assign pb_re = row_ge1 ? xp_re_r : '0;
  assign pb_im = row_ge1 ? xp_im_r : '0;

  assign has_a = row_ge1;
  assign has_b = last_row;

  // Result for the previous row, now that its successor is here
  always_comb begin
    tok_a.lap_re    = lap3(q_re, xp_re_r, in_x_re);
    tok_a.lap_im    = lap3(q_im, xp_im_r, in_x_im);
    tok_a.y_re      = yp_re_r;
    tok_a.y_im      = yp_im_r;
    tok_a.meta.row  = row_cnt_r - 1'b1;
    tok_a.meta.col  = col_cnt_r;
    tok_a.meta.last = !last_row;
    tok_a.meta.eom  = 1'b0;
  end

  // Result for the last row itself, lower neighbor is the boundary
  always_comb begin
    tok_b.lap_re    = lap3(pb_re, in_x_re, '0);
    tok_b.lap_im    = lap3(pb_im, in_x_im, '0);
    tok_b.y_re      = in_y_old_re;
    tok_b.y_im      = in_y_old_im;
    tok_b.meta.row  = row_cnt_r;
    tok_b.meta.col  = col_cnt_r;
    tok_b.meta.last = 1'b1;
    tok_b.meta.eom  = last_col;
  end

  // Advance the position counters
  always_comb begin
    if (last_row) begin
      row_cnt_nxt = '0;
      col_cnt_nxt = last_col ? '0 : col_cnt_r + 1'b1;
    end else begin
      row_cnt_nxt = row_cnt_r + 1'b1;
      col_cnt_nxt = col_cnt_r;
    end
  end

  // ---------------------------------------------------------------------
  // Issue stage: up to two tokens, handed on while the multiplier stage is ready, one per cycle
  // ---------------------------------------------------------------------
  tok_t tok_a_r, tok_b_r, iss_tok;
  logic tok_a_v_r, tok_b_v_r;
  logic s2_v_r, out_v_r;
  logic s3_rdy, s2_rdy, issue, s1_free, in_acc;

  assign s3_rdy  = !out_v_r || !out_stall;
  assign s2_rdy  = !s2_v_r || s3_rdy;
  assign issue   = (tok_a_v_r || tok_b_v_r) && s2_rdy;
  assign iss_tok = tok_a_v_r ? tok_a_r : tok_b_r;
  assign s1_free = (!tok_a_v_r && !tok_b_v_r) || (issue && !(tok_a_v_r && tok_b_v_r));
  assign in_acc  = in_valid && s1_free;
  assign in_stall = !s1_free;

  // ---------------------------------------------------------------------
  // Multiplier stage
  // ---------------------------------------------------------------------
  logic signed [DATA_BITS-1:0] iss_lr, iss_li, iss_yr, iss_yi;
  logic signed [PROD_W-1:0]    m_ar_lr_r, m_ai_li_r, m_br_yr_r, m_bi_yi_r;
  logic signed [PROD_W-1:0]    m_ar_li_r, m_ai_lr_r, m_br_yi_r, m_bi_yr_r;
  meta_t                       s2_meta_r;

  assign iss_lr = iss_tok.lap_re;
  assign iss_li = iss_tok.lap_im;
  assign iss_yr = iss_tok.y_re;
  assign iss_yi = iss_tok.y_im;

  // ---------------------------------------------------------------------
  // Sum and saturate into the result register
  // ---------------------------------------------------------------------
  logic signed [SUM_W-1:0]     sum_re, sum_im;
  logic signed [DATA_BITS-1:0] out_y_re_r, out_y_im_r;
  meta_t                       out_meta_r;

  assign sum_re = fshift(m_ar_lr_r) - fshift(m_ai_li_r) + fshift(m_br_yr_r) - fshift(m_bi_yi_r);
  assign sum_im = fshift(m_ar_li_r) + fshift(m_ai_lr_r) + fshift(m_br_yi_r) + fshift(m_bi_yr_r);

  // Control state, history and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_per_col_r <= LEN_BITS'(1);
      col_total_r    <= LEN_BITS'(1);
      alpha_re_r <= D_ONE;
      alpha_im_r <= '0;
      beta_re_r  <= '0;
      beta_im_r  <= '0;
      row_cnt_r  <= '0;
      col_cnt_r  <= '0;
      xp_re_r    <= '0;
      xp_im_r    <= '0;
      xp2_re_r   <= '0;
      xp2_im_r   <= '0;
      yp_re_r    <= '0;
      yp_im_r    <= '0;
      tok_a_v_r  <= 1'b0;
      tok_b_v_r  <= 1'b0;
      s2_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      // register writes
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_ROWS_PER_COL: rows_per_col_r <= pwdata[LEN_BITS-1:0];
          REG_COL_TOTAL:    col_total_r    <= pwdata[LEN_BITS-1:0];
          REG_ALPHA_RE:     alpha_re_r     <= pwdata[DATA_BITS-1:0];
          REG_ALPHA_IM:     alpha_im_r     <= pwdata[DATA_BITS-1:0];
          REG_BETA_RE:      beta_re_r      <= pwdata[DATA_BITS-1:0];
          REG_BETA_IM:      beta_im_r      <= pwdata[DATA_BITS-1:0];
          default: ;
        endcase
      end

      // take an input transfer: shift history or clear it at column end
      if (in_acc) begin
        row_cnt_r <= row_cnt_nxt;
        col_cnt_r <= col_cnt_nxt;
        if (last_row) begin
          xp_re_r  <= '0;
          xp_im_r  <= '0;
          xp2_re_r <= '0;
          xp2_im_r <= '0;
          yp_re_r  <= '0;
          yp_im_r  <= '0;
        end else begin
          xp2_re_r <= xp_re_r;
          xp2_im_r <= xp_im_r;
          xp_re_r  <= in_x_re;
          xp_im_r  <= in_x_im;
          yp_re_r  <= in_y_old_re;
          yp_im_r  <= in_y_old_im;
        end
        tok_a_v_r <= has_a;
        tok_b_v_r <= has_b;
      end else if (issue) begin
        // drop the token just handed on, A goes first
        if (tok_a_v_r) begin
          tok_a_v_r <= 1'b0;
        end else begin
          tok_b_v_r <= 1'b0;
        end
      end

      if (s2_rdy) begin
        s2_v_r <= issue;
      end
      if (s3_rdy) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tok_a_r <= tok_a;
      tok_b_r <= tok_b;
    end
    if (issue) begin
      m_ar_lr_r <= iss_lr * alpha_re_r;
      m_ai_li_r <= iss_li * alpha_im_r;
      m_br_yr_r <= iss_yr * beta_re_r;
      m_bi_yi_r <= iss_yi * beta_im_r;
      m_ar_li_r <= iss_li * alpha_re_r;
      m_ai_lr_r <= iss_lr * alpha_im_r;
      m_br_yi_r <= iss_yi * beta_re_r;
      m_bi_yr_r <= iss_yr * beta_im_r;
      s2_meta_r <= iss_tok.meta;
    end
    if (s2_v_r && s3_rdy) begin
      out_y_re_r <= sat_d(sum_re);
      out_y_im_r <= sat_d(sum_im);
      out_meta_r <= s2_meta_r;
    end
  end

  assign out_valid         = out_v_r;
  assign out_y_re          = out_y_re_r;
  assign out_y_im          = out_y_im_r;
  assign out_row_index     = out_meta_r.row;
  assign out_col_index     = out_meta_r.col;
  assign out_last          = out_meta_r.last;
  assign out_end_of_matrix = out_meta_r.eom;

endmodule

// ===== hdl/tpsa_checker.sv =====
// Port checker for the three-point stencil axpby block, bound to the top level.
// Depends on tpsa_pkg and the assertion macros header.
`include "three_point_stencil_axpby_assert.svh"

module tpsa_checker #(
  parameter int DATA_BITS  = tpsa_pkg::DATA_BITS_DEF,
  parameter int INDEX_BITS = tpsa_pkg::INDEX_BITS_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic signed [DATA_BITS-1:0] out_y_re,
  input logic signed [DATA_BITS-1:0] out_y_im,
  input logic [INDEX_BITS-1:0]       out_row_index,
  input logic [INDEX_BITS-1:0]       out_col_index,
  input logic                        out_last,
  input logic                        out_end_of_matrix
);
  import tpsa_pkg::*;

  // A stalled result stays put until its transfer
  `TPSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_y_re) && $stable(out_y_im) && $stable(out_row_index) && $stable(out_col_index), "stalled result changed")

  // The end of the matrix is always the final result of its input
  `TPSA_ASSERT_NOW(a_eom_last, out_valid && out_end_of_matrix, out_last, "end_of_matrix without last")

  // Coming out of reset the pipeline is empty and ready
  `TPSA_ASSERT_NOW(a_reset_idle, $past(!rst_n), !out_valid && !in_stall, "not idle after reset")

endmodule

bind three_point_stencil_axpby tpsa_checker #(
  .DATA_BITS (DATA_BITS),
  .INDEX_BITS(INDEX_BITS)
) u_tpsa_checker (.*);
